/* rtl/token_table_lexer_defines.svh */
// Assertion macros for the token table lexer.
`ifndef TOKEN_TABLE_LEXER_DEFINES_SVH
`define TOKEN_TABLE_LEXER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TTL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TTL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/ttl_pkg.sv */
// Package for the token table lexer: types and constants.
package ttl_pkg;
  localparam int LookDepth = 8;
  localparam int EntryRegs = 4;
  localparam logic [1:0] KindWord  = 2'd0;
  localparam logic [1:0] KindEntry = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;
  localparam logic [2:0] CfgLens   = 3'd4;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RESOLVE,
    ST_FINISH,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  entry_index;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        run_last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a) ||
           (c == 8'h0b) || (c == 8'h0c);
  endfunction
endpackage

/* rtl/token_table_lexer.sv */
// Top level of the token table lexer: cell chain, matcher, sequencer.
// Usage: text bytes enter on the in_ stream (tdata = text_byte, tuser =
// text_end). Tokens leave on the out_ stream, one beat each, tlast marking
// the last token caused by an input byte. Table entries are written on the
// cfg_ port while the block is idle.
// While the lookahead fills, a byte is only loaded. Once it is full, a byte
// is loaded in the fill state and its position resolved in the resolve
// state; a word flushed ahead of an entry token costs one more resolve step.
// A final byte drains the lookahead through the resolve state (an entry
// match takes its whole length at once), then the empty check, the open
// word in the finish state and the end marker in the mark state follow.
// The matcher compares every entry against the cell chain in parallel;
// a matched entry shifts the chain by its length in one shift.
// Results are set by the resolve, finish or mark state and held in the output register.
// Reset clears the buffer, offsets, word state and table registers.
// If the receiver stalls, the output register holds its beat; the next
// byte may still be loaded, but the sequencer waits before a new beat.
module token_table_lexer import ttl_pkg::*; #(
  parameter int TABLE_ENTRIES = 4,
  parameter int ENTRY_MAX_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tuser,   // text_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // start_offset, token_length
  output logic [3:0]  out_tuser,  // kind, entry_index
  output logic        out_tlast,  // run_last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  `include "token_table_lexer_defines.svh"

  localparam int FillMax = (ENTRY_MAX_LEN < LookDepth) ? ENTRY_MAX_LEN : LookDepth;

  logic [EntryRegs-1:0][63:0] entry_bytes_r;
  logic [15:0] entry_lengths_r;
  state_t state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [31:0] pos_r, pos_nxt, wstart_r, wstart_nxt;
  logic [15:0] wlen_r, wlen_nxt;
  logic        inword_r, inword_nxt;
  logic        pend_r, pend_nxt; // entry token waits after a word flush
  logic        last_r, last_nxt; // final byte being drained
  result_t     res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic [LookDepth-1:0][7:0] buf_q, shifted;
  logic [3:0]  shamt;
  logic        do_shift, do_load, do_clear;
  logic        hit;
  logic [1:0]  hit_index;
  logic [3:0]  hit_len;
  logic        accept;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_bytes_r <= '0;
      entry_lengths_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < CfgLens) entry_bytes_r[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == CfgLens) entry_lengths_r <= cfg_data[15:0];
    end
  end

  // Lookahead chain: shift by up to LookDepth positions via per-cell mux
  always_comb begin
    for (int i = 0; i < LookDepth; i++) begin
      shifted[i] = 8'd0;
      for (int s = 1; s <= LookDepth; s++) begin
        if ((32'(shamt) == s) && (i + s < LookDepth)) shifted[i] = buf_q[i + s];
      end
    end
  end

  for (genvar g = 0; g < LookDepth; g++) begin : g_cell
    ttl_cell u_cell (
      .clk(clk), .load(do_load && (fill_r == 4'(g))), .shift(do_shift),
      .clear(do_clear || !rst_n), .load_byte(in_tdata), .right_byte(shifted[g]),
      .byte_q(buf_q[g])
    );
  end

  ttl_match #(.TABLE_ENTRIES(TABLE_ENTRIES), .ENTRY_MAX_LEN(ENTRY_MAX_LEN)) u_match (
    .buf_bytes(buf_q), .fill(fill_r), .entry_bytes(entry_bytes_r),
    .entry_lengths(entry_lengths_r), .hit(hit), .hit_index(hit_index), .hit_len(hit_len)
  );

  // Loading a byte never touches the output register
  assign in_tready = (state_r == ST_FILL);
  assign accept = in_tvalid && in_tready;

  // Sequencer
  always_comb begin
    logic go;
    logic [3:0] len1;
    state_nxt = state_r;
    fill_nxt = fill_r;
    pos_nxt = pos_r;
    wstart_nxt = wstart_r;
    wlen_nxt = wlen_r;
    inword_nxt = inword_r;
    pend_nxt = pend_r;
    last_nxt = last_r;
    res_nxt = res_r;
    ov_nxt = ov_r && !out_tready;
    do_load = 1'b0;
    do_shift = 1'b0;
    do_clear = 1'b0;
    shamt = 4'd0;
    go = !ov_r || out_tready;
    len1 = 4'd1;
    case (state_r)
      ST_FILL: begin
        if (accept) begin
          do_load = (32'(fill_r) < FillMax);
          if (do_load) fill_nxt = fill_r + 4'd1;
          last_nxt = in_tuser;
          if (in_tuser || (32'(fill_nxt) >= FillMax)) state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (go) begin
          if (fill_r == 4'd0) begin
            state_nxt = ST_FINISH;
          end else if (hit && inword_r && !pend_r) begin
            res_nxt = '{KindWord, 2'd0, wstart_r, wlen_r, 1'b0};
            ov_nxt = 1'b1;
            inword_nxt = 1'b0;
            wlen_nxt = 16'd0;
            pend_nxt = 1'b1;
          end else if (hit) begin
            res_nxt = '{KindEntry, hit_index, pos_r, {12'd0, hit_len}, !last_r};
            ov_nxt = 1'b1;
            pend_nxt = 1'b0;
            do_shift = 1'b1;
            shamt = hit_len;
            fill_nxt = fill_r - hit_len;
            pos_nxt = pos_r + 32'(hit_len);
            if (!last_r) state_nxt = ST_FILL;
          end else begin
            do_shift = 1'b1;
            shamt = len1;
            fill_nxt = fill_r - 4'd1;
            pos_nxt = pos_r + 32'd1;
            if (is_space(buf_q[0])) begin
              if (inword_r) begin
                res_nxt = '{KindWord, 2'd0, wstart_r, wlen_r, !last_r};
                ov_nxt = 1'b1;
              end
              inword_nxt = 1'b0;
              wlen_nxt = 16'd0;
            end else if (!inword_r) begin
              inword_nxt = 1'b1;
              wstart_nxt = pos_r;
              wlen_nxt = 16'd1;
            end else if (wlen_r != 16'hffff) begin
              wlen_nxt = wlen_r + 16'd1;
            end
            if (!last_r) state_nxt = ST_FILL;
          end
        end
      end
      ST_FINISH: begin
        if (go) begin
          if (inword_r) begin
            res_nxt = '{KindWord, 2'd0, wstart_r, wlen_r, 1'b0};
            ov_nxt = 1'b1;
          end
          inword_nxt = 1'b0;
          wlen_nxt = 16'd0;
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        if (go) begin
          res_nxt = '{KindEnd, 2'd0, pos_r, 16'd0, 1'b1};
          ov_nxt = 1'b1;
          do_clear = 1'b1;
          fill_nxt = 4'd0;
          pos_nxt = 32'd0;
          wstart_nxt = 32'd0;
          last_nxt = 1'b0;
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r <= 4'd0;
      pos_r <= 32'd0;
      wstart_r <= 32'd0;
      wlen_r <= 16'd0;
      inword_r <= 1'b0;
      pend_r <= 1'b0;
      last_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      pos_r <= pos_nxt;
      wstart_r <= wstart_nxt;
      wlen_r <= wlen_nxt;
      inword_r <= inword_nxt;
      pend_r <= pend_nxt;
      last_r <= last_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {res_r.token_length, res_r.start_offset};
  assign out_tuser = {res_r.entry_index, res_r.kind};
  assign out_tlast = res_r.run_last;

  function automatic logic go_q(input logic v, input logic r);
    return !v || r;
  endfunction

  `TTL_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_r) <= FillMax)
  `TTL_ASSERT_IMP(a_no_accept_busy, state_r != ST_FILL, !in_tready)
  `TTL_ASSERT_NXT(a_mark_clears, (state_r == ST_MARK) && go_q(ov_r, out_tready),
                  (fill_r == 4'd0) && (pos_r == 32'd0))
endmodule

/* rtl/ttl_cell.sv */
// One lookahead cell: holds a buffered byte and shifts toward the head.
module ttl_cell import ttl_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] load_byte,
  input  logic [7:0] right_byte,
  output logic [7:0] byte_q
);
  logic [7:0] byte_r;
  always_ff @(posedge clk) begin
    if (clear) begin
      byte_r <= 8'd0;
    end else if (shift) begin
      byte_r <= right_byte;
    end else if (load) begin
      byte_r <= load_byte;
    end
  end
  assign byte_q = byte_r;
endmodule

/* rtl/ttl_match.sv */
// Entry matcher: first table entry whose bytes equal the buffer head.
module ttl_match import ttl_pkg::*; #(
  parameter int TABLE_ENTRIES = 4,
  parameter int ENTRY_MAX_LEN = 8
) (
  input  logic [LookDepth-1:0][7:0] buf_bytes,
  input  logic [3:0]                fill,
  input  logic [EntryRegs-1:0][63:0] entry_bytes,
  input  logic [15:0]               entry_lengths,
  output logic                      hit,
  output logic [1:0]                hit_index,
  output logic [3:0]                hit_len
);
  logic [EntryRegs-1:0] ok;
  always_comb begin
    for (int e = 0; e < EntryRegs; e++) begin
      logic [3:0] len;
      len = entry_lengths[4*e +: 4];
      ok[e] = (e < TABLE_ENTRIES) && (len != 4'd0) &&
              (32'(len) <= ENTRY_MAX_LEN) && (len <= fill);
      for (int k = 0; k < LookDepth; k++) begin
        if ((k < 32'(len)) && (entry_bytes[e][8*k +: 8] != buf_bytes[k])) ok[e] = 1'b0;
      end
    end
    hit = 1'b0;
    hit_index = 2'd0;
    hit_len = 4'd0;
    for (int e = EntryRegs - 1; e >= 0; e--) begin
      if (ok[e]) begin
        hit = 1'b1;
        hit_index = 2'(e);
        hit_len = entry_lengths[4*e +: 4];
      end
    end
  end
endmodule
